### rtl/dual_key_cooldown_throttle_defines.svh
// Assertion macros for the cooldown throttle.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef DUAL_KEY_COOLDOWN_THROTTLE_DEFINES_SVH
`define DUAL_KEY_COOLDOWN_THROTTLE_DEFINES_SVH
`ifndef SYNTHESIS
`define DKCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DKCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DKCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DKCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/dkct_pkg.sv
// Shared types and constants for the cooldown throttle.
// No dependencies.
package dkct_pkg;
   localparam int unsigned ZONE_ENTRIES_DEF   = 64;
   localparam int unsigned SOURCE_ENTRIES_DEF = 64;
   localparam logic [31:0] STALE_MS = 32'd3600000;
   localparam logic [31:0] SWEEP_MS = STALE_MS / 32'd4;
   localparam logic [9:0]  MS_PER_S = 10'd1000;
   localparam int unsigned ZKEY_W = 34;
   localparam int unsigned SKEY_W = 64;
   localparam logic CSR_ZONE_COOL   = 1'b0;
   localparam logic CSR_SOURCE_COOL = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_STORE = 7'b0000100,
      ST_SWEEP = 7'b0001000,
      ST_WAITW = 7'b0010000,
      ST_RESP  = 7'b0100000,
      ST_MULT  = 7'b1000000
   } state_type;

   // Per-table scan command from the sequencer.
   typedef struct packed {
      logic start_check;
      logic start_store;
      logic start_sweep;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic blocked;
   } tbl_stat_type;
endpackage

### rtl/dkct_table.sv
// One key/time table with a sequential scan unit: lookup, store, stale sweep.
// Depends on dkct_pkg.
module dkct_table import dkct_pkg::*; #(
   parameter int unsigned ENTRIES = ZONE_ENTRIES_DEF,
   parameter int unsigned KEY_W   = ZKEY_W
) (
   input  logic               clock,
   input  logic               reset,
   input  tbl_cmd_type        cmd,
   input  logic [KEY_W-1:0]   key,
   input  logic [31:0]        now_ms,
   input  logic [31:0]        limit_ms,
   output tbl_stat_type       stat
);
   localparam int unsigned IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   typedef enum logic [4:0] {
      T_IDLE = 5'b00001, T_CHECK = 5'b00010, T_STORE = 5'b00100,
      T_SWEEP = 5'b01000, T_WRITE = 5'b10000
   } tstate_type;

   logic [KEY_W-1:0] keys_mem [ENTRIES];
   logic [31:0]      times_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   tstate_type  st_ff, st_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pidx_ff;
   logic          first_ff, first_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [1:0]    slot_kind_ff, slot_kind_in; // 2 match, 1 free, 0 oldest
   logic [31:0]   best_ff, best_in;
   logic          blocked_ff, blocked_in;
   logic          done_ff, done_in;
   logic [KEY_W-1:0] rd_key_ff;
   logic [31:0]   rd_time_ff, age;
   logic          hit;

   assign age = now_ms - rd_time_ff;
   assign hit = valid_ff[pidx_ff] && (rd_key_ff == key);

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; slot_in = slot_ff; slot_kind_in = slot_kind_ff;
      best_in = best_ff; blocked_in = blocked_ff; done_in = 1'b0; valid_in = valid_ff;
      first_in = first_ff;
      unique case (st_ff)
         T_IDLE: begin
            idx_in = '0; first_in = 1'b1;
            if (cmd.start_check) begin
               st_in = T_CHECK; blocked_in = 1'b0;
            end else if (cmd.start_store) begin
               st_in = T_STORE; slot_kind_in = 2'd0; slot_in = '0; best_in = '0;
            end else if (cmd.start_sweep) begin
               st_in = T_SWEEP;
            end
         end
         T_CHECK: begin
            idx_in = idx_ff + 1'b1; first_in = 1'b0;
            if (!first_ff) begin
               if (hit && age < limit_ms) blocked_in = 1'b1;
               if (pidx_ff == LAST) begin
                  st_in = T_IDLE; done_in = 1'b1;
               end
            end
         end
         T_STORE: begin
            idx_in = idx_ff + 1'b1; first_in = 1'b0;
            if (!first_ff) begin
               if (hit && slot_kind_ff != 2'd2) begin
                  slot_kind_in = 2'd2; slot_in = pidx_ff;
               end else if (!valid_ff[pidx_ff] && slot_kind_ff == 2'd0) begin
                  slot_kind_in = 2'd1; slot_in = pidx_ff;
               end else if (slot_kind_ff == 2'd0 && (pidx_ff == '0 || age > best_ff)) begin
                  slot_in = pidx_ff; best_in = age;
               end
               if (pidx_ff == LAST) st_in = T_WRITE;
            end
         end
         T_WRITE: begin
            valid_in[slot_ff] = 1'b1;
            st_in = T_IDLE; done_in = 1'b1;
         end
         T_SWEEP: begin
            idx_in = idx_ff + 1'b1; first_in = 1'b0;
            if (!first_ff) begin
               if (valid_ff[pidx_ff] && age > STALE_MS) valid_in[pidx_ff] = 1'b0;
               if (pidx_ff == LAST) begin
                  st_in = T_IDLE; done_in = 1'b1;
               end
            end
         end
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == T_WRITE) begin
         keys_mem[slot_ff]  <= key;
         times_mem[slot_ff] <= now_ms;
      end
      rd_key_ff  <= keys_mem[idx_ff];
      rd_time_ff <= times_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE; valid_ff <= '0; done_ff <= 1'b0; idx_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         st_ff <= st_in; valid_ff <= valid_in; done_ff <= done_in; idx_ff <= idx_in;
         first_ff <= first_in;
      end
      pidx_ff <= idx_ff;
      slot_ff <= slot_in; slot_kind_ff <= slot_kind_in;
      best_ff <= best_in; blocked_ff <= blocked_in;
   end

   assign stat.done    = done_ff;
   assign stat.blocked = blocked_ff;
endmodule

### rtl/dual_key_cooldown_throttle.sv
// Cooldown throttle keyed by zone and by source.
// req_ takes a request; rsp_ returns allowed and recorded, one per request.
// A check walks both tables; a request that is allowed and recorded then runs
// a store walk and a table write, and a sweep walk after that when a sweep is
// due. Each table is walked one entry a cycle by its scan unit through a
// registered read, both tables in parallel.
// One request at a time; req_tready is low while busy.
// The result is held in a register until rsp_tready; a stall delays the next
// request only. Reset clears all valid bits, the sweep time and the cooldowns
// at once; no clearing pass. Write csr_ only while no request is in flight.
// Cooldown limits (seconds x 1000) are registered while idle and held once a request is taken.
// A cooldown of zero never blocks. Table keys and times hold no reset value.
// Zone key is {zone_id, team}. Full tables overwrite the oldest entry.
// Sweep of entries older than one hour runs at most each quarter hour.
`include "dual_key_cooldown_throttle_defines.svh"
module dual_key_cooldown_throttle import dkct_pkg::*; #(
   parameter int unsigned ZONE_ENTRIES   = ZONE_ENTRIES_DEF,
   parameter int unsigned SOURCE_ENTRIES = SOURCE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // team[1:0], zone_id[33:2], source_id[97:34], now_ms[129:98]
   input  logic         req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // allowed[0], recorded[1]
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   state_type st_ff, st_in;
   logic [15:0] zcool_ff, scool_ff;
   logic [31:0] zlim_ff, slim_ff, last_sweep_ff, last_sweep_in;
   logic        action_ff;
   logic [ZKEY_W-1:0] zkey_ff;
   logic [SKEY_W-1:0] skey_ff;
   logic [31:0] now_ff;
   logic        allowed_ff, allowed_in, recorded_ff, recorded_in, sweep_ff, sweep_in;
   logic        zdone_ff, zdone_in, sdone_ff, sdone_in;
   tbl_cmd_type  zcmd, scmd;
   tbl_stat_type zstat, sstat;
   logic         accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_RESP);
   assign rsp_tdata  = {6'd0, recorded_ff, allowed_ff};

   always_comb begin
      st_in = st_ff; zcmd = '0; scmd = '0;
      allowed_in = allowed_ff; recorded_in = recorded_ff; sweep_in = sweep_ff;
      last_sweep_in = last_sweep_ff;
      zdone_in = zdone_ff || zstat.done; sdone_in = sdone_ff || sstat.done;
      unique case (st_ff)
         ST_IDLE: if (accept) st_in = ST_MULT;
         ST_MULT: begin
            zcmd.start_check = 1'b1; scmd.start_check = 1'b1;
            zdone_in = 1'b0; sdone_in = 1'b0; st_in = ST_CHECK;
         end
         ST_CHECK: if (zdone_in && sdone_in) begin
            allowed_in  = !(zstat.blocked || sstat.blocked);
            recorded_in = allowed_in && action_ff;
            zdone_in = 1'b0; sdone_in = 1'b0;
            if (recorded_in) begin
               zcmd.start_store = 1'b1; scmd.start_store = 1'b1;
               sweep_in = (now_ff - last_sweep_ff) >= SWEEP_MS;
               st_in = ST_STORE;
            end else st_in = ST_RESP;
         end
         ST_STORE: if (zdone_in && sdone_in) begin
            zdone_in = 1'b0; sdone_in = 1'b0;
            if (sweep_ff) begin
               last_sweep_in = now_ff;
               zcmd.start_sweep = 1'b1; scmd.start_sweep = 1'b1;
               st_in = ST_SWEEP;
            end else st_in = ST_RESP;
         end
         ST_SWEEP: if (zdone_in && sdone_in) st_in = ST_WAITW;
         ST_WAITW: st_in = ST_RESP;
         ST_RESP: if (rsp_tready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; zcool_ff <= '0; scool_ff <= '0; last_sweep_ff <= '0;
         zdone_ff <= 1'b0; sdone_ff <= 1'b0;
      end else begin
         st_ff <= st_in; last_sweep_ff <= last_sweep_in;
         zdone_ff <= zdone_in; sdone_ff <= sdone_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ZONE_COOL:   zcool_ff <= csr_wdata;
               CSR_SOURCE_COOL: scool_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (accept) begin
         action_ff <= req_tuser;
         zkey_ff   <= req_tdata[33:0];
         skey_ff   <= req_tdata[97:34];
         now_ff    <= req_tdata[129:98];
      end
      if (st_ff == ST_IDLE) begin
         zlim_ff <= 32'(zcool_ff) * 32'(MS_PER_S);
         slim_ff <= 32'(scool_ff) * 32'(MS_PER_S);
      end
      allowed_ff <= allowed_in; recorded_ff <= recorded_in; sweep_ff <= sweep_in;
   end

   dkct_table #(.ENTRIES(ZONE_ENTRIES), .KEY_W(ZKEY_W)) u_zone (
      .clock(clock), .reset(reset), .cmd(zcmd), .key(zkey_ff), .now_ms(now_ff),
      .limit_ms(zlim_ff), .stat(zstat));
   dkct_table #(.ENTRIES(SOURCE_ENTRIES), .KEY_W(SKEY_W)) u_source (
      .clock(clock), .reset(reset), .cmd(scmd), .key(skey_ff), .now_ms(now_ff),
      .limit_ms(slim_ff), .stat(sstat));

   `DKCT_ASSERT_IMPL(a_rec_allowed, clock, reset, rsp_tvalid, (!recorded_ff || allowed_ff), "recorded without allowed")
   `DKCT_ASSERT_IMPL(a_busy, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `DKCT_ASSERT_NEXT(a_sweep, clock, reset, (st_ff == ST_SWEEP), (last_sweep_ff == now_ff), "sweep time not taken")
endmodule
